>>> rtl/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths and codes for the capsule / swept sphere collision core.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int POINT_W     = 63;  // packed z:y:x point
  localparam int RADIUS_W    = 16;
  localparam int RADIUS_FRAC = 8;
  localparam int DIST_W      = 48;
  localparam int DIST_FRAC   = 16;

  // How a clamped ratio n/d resolves
  typedef enum logic [1:0] {
    RK_ZERO,
    RK_ONE,
    RK_DIV
  } ratio_kind_t;

endpackage

>>> rtl/csc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_if
// Valid/ready channels for query beats and result beats.
// ----------------------------------------------------------------------------
interface csc_in_if;
  logic                          valid;
  logic                          ready;
  logic [csc_pkg::POINT_W-1:0]   capsule_start;
  logic [csc_pkg::POINT_W-1:0]   capsule_end;
  logic [csc_pkg::POINT_W-1:0]   path_start;
  logic [csc_pkg::POINT_W-1:0]   path_end;
  logic [csc_pkg::RADIUS_W-1:0]  capsule_radius;
  logic [csc_pkg::RADIUS_W-1:0]  sphere_radius;

  modport source (
    output valid, capsule_start, capsule_end, path_start, path_end,
           capsule_radius, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, capsule_start, capsule_end, path_start, path_end,
           capsule_radius, sphere_radius,
    output ready
  );
endinterface

interface csc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [csc_pkg::DIST_W-1:0]  distance_squared;

  modport source (output valid, hit, distance_squared, input ready);
  modport sink (input valid, hit, distance_squared, output ready);
endinterface

>>> rtl/csc_wmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_wmul
// Two-stage signed W x W multiplier built from four half-width partials.
// ----------------------------------------------------------------------------
module csc_wmul #(
  parameter int W = 46
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   x,
  input  logic signed [W-1:0]   y,
  output logic signed [2*W-1:0] p
);

  localparam int H  = W / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;

  logic signed [H:0]      xl, yl;   // low halves, zero-extended
  logic signed [HW-1:0]   xh, yh;   // high halves keep the sign

  logic signed [2*H+1:0]  ll_r;
  logic signed [HW+H:0]   hl_r, lh_r;
  logic signed [2*HW-1:0] hh_r;
  logic signed [PW-1:0]   p_r, p_nxt;

  assign xl = $signed({1'b0, x[H-1:0]});
  assign yl = $signed({1'b0, y[H-1:0]});
  assign xh = x[W-1:H];
  assign yh = y[W-1:H];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= xl * yl;
      hl_r <= xh * yl;
      lh_r <= xl * yh;
      hh_r <= xh * yh;
      p_r  <= p_nxt;
    end
  end

  always_comb begin
    p_nxt = (PW'(hh_r) <<< (2 * H)) + ((PW'(hl_r) + PW'(lh_r)) <<< H) + PW'(ll_r);
  end

  assign p = p_r;

endmodule

>>> rtl/csc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_div
// Pipelined restoring divider: floor(num * 2^QW / den) for num < den,
// one quotient bit per stage, side payload carried alongside.
// ----------------------------------------------------------------------------
module csc_div #(
  parameter int DW     = 92,
  parameter int QW     = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QW-1:0]     quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              v_r    [QW];
  logic [DW-1:0]     rem_r  [QW];
  logic [DW-1:0]     den_r  [QW];
  logic [QW-1:0]     q_r    [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic              v_in;
    logic [DW-1:0]     rem_in;
    logic [DW-1:0]     den_in;
    logic [QW-1:0]     q_in;
    logic [SIDE_W-1:0] side_s;
    logic [DW:0]       rem2;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign side_s = side_in;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign side_s = side_r[i-1];
    end

    assign rem2 = {rem_in, 1'b0};
    assign ge   = rem2 >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? DW'(rem2 - {1'b0, den_in}) : rem2[DW-1:0];
        den_r[i]  <= den_in;
        q_r[i]    <= {q_in[QW-2:0], ge};
        side_r[i] <= side_s;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo       = q_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

>>> rtl/capsule_swept_sphere_collision_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_swept_sphere_collision_core
// Closest squared distance between a capsule axis and a sphere path, with hit.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; set by the
//   single-issue pipeline, each of the two divider chains resolves one
//   quotient bit per stage.
// Stalls freeze the whole pipeline while the result register is held.
// Reset (rst_n low, synchronous) clears all valid bits; no results in flight.
module capsule_swept_sphere_collision_core #(
  parameter int COORD_BITS      = 21,
  parameter int COORD_FRAC_BITS = 8,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  csc_in_if.sink    in_ch,
  csc_out_if.source out_ch
);

  localparam int CW   = COORD_BITS;
  localparam int DW1  = CW + 1;
  localparam int PF   = PARAM_FRAC_BITS;
  localparam int SW   = PF + 1;
  localparam int AW   = 2 * DW1 + 2;
  localparam int MW   = 2 * AW + 1;
  localparam int NTW  = AW + SW + 1;
  localparam int DKW  = DW1 + PF + 3;
  localparam int ACW  = 2 * DKW + 2;
  localparam int RW   = csc_pkg::RADIUS_W + 1;
  localparam int RQW  = 2 * RW;
  localparam int OUT_SHIFT = 2 * PF + 2 * COORD_FRAC_BITS - csc_pkg::DIST_FRAC;
  localparam int RAD_SHIFT = OUT_SHIFT + csc_pkg::DIST_FRAC - 2 * csc_pkg::RADIUS_FRAC;
  localparam int LIMW = RQW + RAD_SHIFT;
  localparam int CMPW = (ACW > LIMW) ? ACW : LIMW;
  localparam int EXW  = ACW + csc_pkg::DIST_W;
  localparam logic [SW-1:0] PONE = SW'(1) << PF;

  typedef struct packed {
    logic [2:0][DW1-1:0] d1;
    logic [2:0][DW1-1:0] d2;
    logic [2:0][DW1-1:0] r;
  } vec_t;

  typedef struct packed {
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] c;
    logic signed [AW-1:0] e;
    logic signed [AW-1:0] f;
    vec_t                 v;
    logic [RQW-1:0]       rsq;
  } geo_t;

  typedef struct packed {
    geo_t                  g;
    csc_pkg::ratio_kind_t  kind;
  } d1_side_t;

  typedef struct packed {
    geo_t                  g;
    logic                  to_s;
    logic [SW-1:0]         fix;
    csc_pkg::ratio_kind_t  kind;
  } d2_side_t;

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 1: differences, radius sum
  vec_t          vec1_r, vec1_nxt;
  logic [RW-1:0] rsum_r, rsum_nxt;
  logic          v1_r;

  always_comb begin
    logic signed [CW-1:0] p1, p2, p3, p4;
    for (int k = 0; k < 3; k++) begin
      p1 = in_ch.capsule_start[k*CW +: CW];
      p2 = in_ch.capsule_end[k*CW +: CW];
      p3 = in_ch.path_start[k*CW +: CW];
      p4 = in_ch.path_end[k*CW +: CW];
      vec1_nxt.d1[k] = DW1'(p2) - DW1'(p1);
      vec1_nxt.d2[k] = DW1'(p4) - DW1'(p3);
      vec1_nxt.r[k]  = DW1'(p1) - DW1'(p3);
    end
    rsum_nxt = {1'b0, in_ch.capsule_radius} + {1'b0, in_ch.sphere_radius};
  end

  // ---------------- stage 2: coordinate products
  vec_t                    vec2_r;
  logic signed [2*DW1-1:0] paa_r [3], pee_r [3], pbb_r [3], pcc_r [3], pff_r [3];
  logic [RQW-1:0]          rsq2_r;
  logic                    v2_r;

  // ---------------- stage 3: dot products
  geo_t geo3_r, geo3_nxt;
  logic v3_r;

  always_comb begin
    geo3_nxt.a   = AW'(paa_r[0]) + AW'(paa_r[1]) + AW'(paa_r[2]);
    geo3_nxt.e   = AW'(pee_r[0]) + AW'(pee_r[1]) + AW'(pee_r[2]);
    geo3_nxt.b   = AW'(pbb_r[0]) + AW'(pbb_r[1]) + AW'(pbb_r[2]);
    geo3_nxt.c   = AW'(pcc_r[0]) + AW'(pcc_r[1]) + AW'(pcc_r[2]);
    geo3_nxt.f   = AW'(pff_r[0]) + AW'(pff_r[1]) + AW'(pff_r[2]);
    geo3_nxt.v   = vec2_r;
    geo3_nxt.rsq = rsq2_r;
  end

  // ---------------- stages 4-5: wide products
  geo_t                 geo4_r, geo5_r;
  logic                 v4_r, v5_r;
  logic signed [2*AW-1:0] p_ae, p_bb, p_bf, p_ce;

  csc_wmul #(.W(AW)) u_mul_ae (.clk(clk), .en(en), .x(geo3_r.a), .y(geo3_r.e), .p(p_ae));
  csc_wmul #(.W(AW)) u_mul_bb (.clk(clk), .en(en), .x(geo3_r.b), .y(geo3_r.b), .p(p_bb));
  csc_wmul #(.W(AW)) u_mul_bf (.clk(clk), .en(en), .x(geo3_r.b), .y(geo3_r.f), .p(p_bf));
  csc_wmul #(.W(AW)) u_mul_ce (.clk(clk), .en(en), .x(geo3_r.c), .y(geo3_r.e), .p(p_ce));

  // ---------------- stage 6: denominator / numerator for s
  logic signed [MW-1:0] denom_r, numer1_r;
  geo_t                 geo6_r;
  logic                 v6_r;

  csc_pkg::ratio_kind_t kind1;
  logic [MW-2:0]        div1_num, div1_den;
  d1_side_t             div1_in, div1_out;
  logic                 dv1_valid;
  logic [PF-1:0]        dv1_quo;

  always_comb begin
    priority if (geo6_r.a == '0 || geo6_r.e == '0 || denom_r == '0) begin
      kind1 = csc_pkg::RK_ZERO;   // point segment or parallel: s = 0
    end else if (numer1_r[MW-1] || numer1_r == '0) begin
      kind1 = csc_pkg::RK_ZERO;
    end else if (numer1_r >= denom_r) begin
      kind1 = csc_pkg::RK_ONE;
    end else begin
      kind1 = csc_pkg::RK_DIV;
    end
    div1_num     = (kind1 == csc_pkg::RK_DIV) ? numer1_r[MW-2:0] : '0;
    div1_den     = (kind1 == csc_pkg::RK_DIV) ? denom_r[MW-2:0] : (MW-1)'(1);
    div1_in.g    = geo6_r;
    div1_in.kind = kind1;
  end

  csc_div #(.DW(MW-1), .QW(PF), .SIDE_W($bits(d1_side_t))) u_div_s (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v6_r), .num(div1_num), .den(div1_den), .side_in(div1_in),
    .out_valid(dv1_valid), .quo(dv1_quo), .side_out(div1_out)
  );

  // ---------------- stage 7: t numerator from quantized s
  logic signed [NTW-1:0] numt_r, numt_nxt;
  logic [SW-1:0]         s1_r, s1_nxt;
  geo_t                  geo7_r;
  logic                  v7_r;

  always_comb begin
    logic signed [NTW-1:0] bs;
    unique case (div1_out.kind)
      csc_pkg::RK_ONE: s1_nxt = PONE;
      csc_pkg::RK_DIV: s1_nxt = {1'b0, dv1_quo};
      default:         s1_nxt = '0;
    endcase
    bs       = div1_out.g.b * $signed({1'b0, s1_nxt});
    numt_nxt = bs + (NTW'(div1_out.g.f) <<< PF);
  end

  // ---------------- stage 8: pick the second ratio
  logic signed [NTW-1:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic                  to_s_r, to_s_nxt;
  logic [SW-1:0]         fix_r, fix_nxt;
  geo_t                  geo8_r;
  logic                  v8_r;

  always_comb begin
    logic signed [NTW-1:0] dent;
    logic signed [AW:0]    negc, bmc;
    logic                  a0, e0;
    dent = NTW'(geo7_r.e) <<< PF;
    negc = -(AW+1)'(geo7_r.c);
    bmc  = (AW+1)'(geo7_r.b) - (AW+1)'(geo7_r.c);
    a0   = geo7_r.a == '0;
    e0   = geo7_r.e == '0;
    priority if (a0 && e0) begin
      rn_nxt = '0;           rd_nxt = NTW'(1);        to_s_nxt = 1'b0; fix_nxt = '0;
    end else if (a0) begin
      rn_nxt = NTW'(geo7_r.f); rd_nxt = NTW'(geo7_r.e); to_s_nxt = 1'b0; fix_nxt = '0;
    end else if (e0) begin
      rn_nxt = NTW'(negc);   rd_nxt = NTW'(geo7_r.a); to_s_nxt = 1'b1; fix_nxt = '0;
    end else if (numt_r[NTW-1]) begin
      // t below zero: t = 0, redo s
      rn_nxt = NTW'(negc);   rd_nxt = NTW'(geo7_r.a); to_s_nxt = 1'b1; fix_nxt = '0;
    end else if (numt_r > dent) begin
      // t above one: t = 1, redo s
      rn_nxt = NTW'(bmc);    rd_nxt = NTW'(geo7_r.a); to_s_nxt = 1'b1; fix_nxt = PONE;
    end else begin
      rn_nxt = numt_r;       rd_nxt = dent;           to_s_nxt = 1'b0; fix_nxt = s1_r;
    end
  end

  // ---------------- second divider
  csc_pkg::ratio_kind_t kind2;
  logic [NTW-2:0]       div2_num, div2_den;
  d2_side_t             div2_in, div2_out;
  logic                 dv2_valid;
  logic [PF-1:0]        dv2_quo;

  always_comb begin
    priority if (rn_r[NTW-1] || rn_r == '0) begin
      kind2 = csc_pkg::RK_ZERO;
    end else if (rn_r >= rd_r) begin
      kind2 = csc_pkg::RK_ONE;
    end else begin
      kind2 = csc_pkg::RK_DIV;
    end
    div2_num     = (kind2 == csc_pkg::RK_DIV) ? rn_r[NTW-2:0] : '0;
    div2_den     = (kind2 == csc_pkg::RK_DIV) ? rd_r[NTW-2:0] : (NTW-1)'(1);
    div2_in.g    = geo8_r;
    div2_in.to_s = to_s_r;
    div2_in.fix  = fix_r;
    div2_in.kind = kind2;
  end

  csc_div #(.DW(NTW-1), .QW(PF), .SIDE_W($bits(d2_side_t))) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v8_r), .num(div2_num), .den(div2_den), .side_in(div2_in),
    .out_valid(dv2_valid), .quo(dv2_quo), .side_out(div2_out)
  );

  // ---------------- stage 10: final s, t
  logic [SW-1:0]  sq_r, sq_nxt, tq_r, tq_nxt;
  vec_t           vec10_r;
  logic [RQW-1:0] rsq10_r;
  logic           v10_r;

  always_comb begin
    logic [SW-1:0] q2;
    unique case (div2_out.kind)
      csc_pkg::RK_ONE: q2 = PONE;
      csc_pkg::RK_DIV: q2 = {1'b0, dv2_quo};
      default:         q2 = '0;
    endcase
    sq_nxt = div2_out.to_s ? q2 : div2_out.fix;
    tq_nxt = div2_out.to_s ? div2_out.fix : q2;
  end

  // ---------------- stage 11: closest-point difference
  logic signed [DKW-1:0] dk_r [3], dk_nxt [3];
  logic [RQW-1:0]        rsq11_r;
  logic                  v11_r;

  always_comb begin
    logic signed [DKW-1:0] t1, t2;
    for (int k = 0; k < 3; k++) begin
      t1 = $signed(vec10_r.d1[k]) * $signed({1'b0, sq_r});
      t2 = $signed(vec10_r.d2[k]) * $signed({1'b0, tq_r});
      dk_nxt[k] = (DKW'($signed(vec10_r.r[k])) <<< PF) + t1 - t2;
    end
  end

  // ---------------- stages 12-13: squares
  logic signed [2*DKW-1:0] sqk [3];
  logic [RQW-1:0]          rsq12_r, rsq13_r;
  logic                    v12_r, v13_r;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    csc_wmul #(.W(DKW)) u_mul_sq (
      .clk(clk), .en(en), .x(dk_r[k]), .y(dk_r[k]), .p(sqk[k])
    );
  end

  // ---------------- stage 14: sum of squares, hit limit
  logic [ACW-1:0]  acc_r, acc_nxt;
  logic [LIMW-1:0] lim_r, lim_nxt;
  logic            v14_r;

  always_comb begin
    acc_nxt = ACW'(sqk[0]) + ACW'(sqk[1]) + ACW'(sqk[2]);
    lim_nxt = LIMW'(rsq13_r) << RAD_SHIFT;
  end

  // ---------------- result register
  logic                       hit_r, hit_nxt;
  logic [csc_pkg::DIST_W-1:0] dist_r, dist_nxt;

  always_comb begin
    logic [EXW-1:0] acc_x;
    acc_x    = EXW'(acc_r) >> OUT_SHIFT;
    hit_nxt  = CMPW'(acc_r) <= CMPW'(lim_r);
    dist_nxt = (|acc_x[EXW-1:csc_pkg::DIST_W]) ? '1 : acc_x[csc_pkg::DIST_W-1:0];
  end

  // ---------------- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;  v2_r <= 1'b0;  v3_r <= 1'b0;  v4_r <= 1'b0;
      v5_r <= 1'b0;  v6_r <= 1'b0;  v7_r <= 1'b0;  v8_r <= 1'b0;
      v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0; v13_r <= 1'b0;
      v14_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= dv1_valid;
      v8_r        <= v7_r;
      v10_r       <= dv2_valid;
      v11_r       <= v10_r;
      v12_r       <= v11_r;
      v13_r       <= v12_r;
      v14_r       <= v13_r;
      out_valid_r <= v14_r;
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      vec1_r <= vec1_nxt;
      rsum_r <= rsum_nxt;

      vec2_r <= vec1_r;
      rsq2_r <= rsum_r * rsum_r;
      for (int k = 0; k < 3; k++) begin
        paa_r[k] <= $signed(vec1_r.d1[k]) * $signed(vec1_r.d1[k]);
        pee_r[k] <= $signed(vec1_r.d2[k]) * $signed(vec1_r.d2[k]);
        pbb_r[k] <= $signed(vec1_r.d1[k]) * $signed(vec1_r.d2[k]);
        pcc_r[k] <= $signed(vec1_r.d1[k]) * $signed(vec1_r.r[k]);
        pff_r[k] <= $signed(vec1_r.d2[k]) * $signed(vec1_r.r[k]);
      end

      geo3_r <= geo3_nxt;
      geo4_r <= geo3_r;
      geo5_r <= geo4_r;

      denom_r  <= MW'(p_ae) - MW'(p_bb);
      numer1_r <= MW'(p_bf) - MW'(p_ce);
      geo6_r   <= geo5_r;

      numt_r <= numt_nxt;
      s1_r   <= s1_nxt;
      geo7_r <= div1_out.g;

      rn_r   <= rn_nxt;
      rd_r   <= rd_nxt;
      to_s_r <= to_s_nxt;
      fix_r  <= fix_nxt;
      geo8_r <= geo7_r;

      sq_r    <= sq_nxt;
      tq_r    <= tq_nxt;
      vec10_r <= div2_out.g.v;
      rsq10_r <= div2_out.g.rsq;

      for (int k = 0; k < 3; k++) begin
        dk_r[k] <= dk_nxt[k];
      end
      rsq11_r <= rsq10_r;
      rsq12_r <= rsq11_r;
      rsq13_r <= rsq12_r;

      acc_r <= acc_nxt;
      lim_r <= lim_nxt;

      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.hit              = hit_r;
  assign out_ch.distance_squared = dist_r;

  // ---------------- checks
  a_sqlen_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (!geo3_r.a[AW-1] && !geo3_r.e[AW-1]))
    else $error("negative squared segment length");

  a_denom_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> !denom_r[MW-1])
    else $error("negative a*e - b*b");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    v10_r |-> (sq_r <= PONE && tq_r <= PONE))
    else $error("segment parameter outside [0,1]");

endmodule
